// ----- rtl/core/bf_pkg.sv -----
// bf_pkg: shared types and constants for the blowfish engine
// no dependencies; used by bf_feistel and blowfish_block_cipher_top

package bf_pkg;

  // operation codes
  localparam logic [1:0] OP_LOAD = 2'd0;
  localparam logic [1:0] OP_MIX  = 2'd1;
  localparam logic [1:0] OP_ENC  = 2'd2;
  localparam logic [1:0] OP_DEC  = 2'd3;

  localparam int unsigned ROUND_KEYS = 18;
  localparam int unsigned BOX_WORDS  = 256;

  localparam logic [10:0] TABLE_WORDS = 11'd1042;
  localparam logic [10:0] BOX_BASE    = 11'd18;
  localparam logic [10:0] LAST_PAIR   = 11'd1040;
  localparam logic [3:0]  LAST_ROUND  = 4'd15;
  localparam logic [4:0]  KEY_LAST    = 5'd17;
  localparam logic [4:0]  KEY_PRE     = 5'd16;
  localparam logic [4:0]  KEY_FIRST   = 5'd0;
  localparam logic [4:0]  KEY_SECOND  = 5'd1;

  typedef struct packed {
    logic [1:0]  operation;
    logic [10:0] table_index;
    logic [31:0] table_word;
    logic [63:0] key_bytes;
    logic [31:0] block_first;
    logic [31:0] block_second;
  } bf_in_t;

  typedef struct packed {
    logic [31:0] result_first;
    logic [31:0] result_second;
  } bf_out_t;

  // box bank request: one write and one four-byte lookup per cycle
  typedef struct packed {
    logic        wr_en;
    logic [1:0]  wr_box;
    logic [7:0]  wr_addr;
    logic [31:0] wr_data;
    logic [31:0] rd_word;
  } bf_box_req_t;

endpackage

// ----- rtl/core/bf_sbox_ram.sv -----
// bf_sbox_ram: one 256 x 32 substitution box, one write and one registered read
// no dependencies

module bf_sbox_ram (
  input  logic        clk_i,
  input  logic        wr_en_i,
  input  logic [7:0]  wr_addr_i,
  input  logic [31:0] wr_data_i,
  input  logic [7:0]  rd_addr_i,
  output logic [31:0] rd_data_o
);

  logic [31:0] mem [256];
  logic [31:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_data_q <= mem[rd_addr_i];
  end

  assign rd_data_o = rd_data_q;

endmodule

// ----- rtl/core/bf_feistel.sv -----
// bf_feistel: four box memories and the round function f
// depends on bf_pkg and bf_sbox_ram

module bf_feistel (
  input  logic                clk_i,
  input  bf_pkg::bf_box_req_t req_i,
  output logic [31:0]         f_o
);

  logic [31:0] box_data [4];

  for (genvar g = 0; g < 4; g++) begin : g_box
    bf_sbox_ram u_ram (
      .clk_i     (clk_i),
      .wr_en_i   (req_i.wr_en && (req_i.wr_box == 2'(g))),
      .wr_addr_i (req_i.wr_addr),
      .wr_data_i (req_i.wr_data),
      .rd_addr_i (req_i.rd_word[8*(3-g) +: 8]),
      .rd_data_o (box_data[g])
    );
  end

  // box data arrives in the cycle after the lookup word, through the registered read
  assign f_o = ((box_data[0] + box_data[1]) ^ box_data[2]) + box_data[3];

endmodule

// ----- rtl/core/blowfish_block_cipher_top.sv -----
// Blowfish engine: 18 round keys in flops, four 256-word boxes in memories.
// A load writes its table word, if the index is in range, then publishes.
// Encrypt and decrypt run 16 rounds, each a lookup step and an f step split
// by the registered read of the box memories feeding f, then publish. Key mix
// XORs the key into the round keys, then runs 521 encryptions, each followed
// by two single-port writes of its result. Input stall is high from acceptance
// until the result is placed in the output register, which may still be
// waiting to be taken while the next transaction is accepted.
// depends on bf_pkg and bf_feistel

module blowfish_block_cipher_top (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  bf_pkg::bf_in_t  in_data_i,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output bf_pkg::bf_out_t out_data_o
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_LOAD = 3'd1;
  localparam logic [2:0] ST_KXOR = 3'd2;
  localparam logic [2:0] ST_RD   = 3'd3;
  localparam logic [2:0] ST_FN   = 3'd4;
  localparam logic [2:0] ST_WR0  = 3'd5;
  localparam logic [2:0] ST_WR1  = 3'd6;
  localparam logic [2:0] ST_DONE = 3'd7;

  logic [2:0]  state_q, state_d;
  logic [3:0]  round_q, round_d;
  logic [10:0] pair_q, pair_d;
  logic [1:0]  op_q, op_d;
  logic [10:0] idx_q, idx_d;
  logic [31:0] word_q, word_d;
  logic [63:0] key_q, key_d;
  logic [31:0] l_q, l_d;
  logic [31:0] r_q, r_d;
  logic [31:0] t_q, t_d;
  logic [31:0] p_q [bf_pkg::ROUND_KEYS];
  logic [31:0] p_d [bf_pkg::ROUND_KEYS];
  logic        out_valid_q, out_valid_d;
  bf_pkg::bf_out_t out_data_q, out_data_d;

  bf_pkg::bf_box_req_t box_req;
  logic [31:0] f_val;
  logic        accept;
  logic [4:0]  key_idx;
  logic [31:0] key_even, key_odd;
  logic        wr_go;
  logic [10:0] wr_idx;
  logic [31:0] wr_val;
  logic [10:0] box_ofs;
  logic [31:0] l_next;
  logic [31:0] fin_first, fin_second;

  bf_feistel u_feistel (
    .clk_i (clk_i),
    .req_i (box_req),
    .f_o   (f_val)
  );

  assign in_stall_o  = (state_q != ST_IDLE);
  assign accept      = in_valid_i && !in_stall_o;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  // decrypt walks the round keys from the top down
  assign key_idx = (op_q == bf_pkg::OP_DEC) ? (bf_pkg::KEY_LAST - {1'b0, round_q})
                                            : {1'b0, round_q};

  // key bytes taken big-endian, the eight bytes repeating every two words
  assign key_even = {key_q[7:0], key_q[15:8], key_q[23:16], key_q[31:24]};
  assign key_odd  = {key_q[39:32], key_q[47:40], key_q[55:48], key_q[63:56]};

  assign l_next     = r_q ^ f_val;
  assign fin_first  = t_q ^ ((op_q == bf_pkg::OP_DEC) ? p_q[bf_pkg::KEY_FIRST]
                                                      : p_q[bf_pkg::KEY_LAST]);
  assign fin_second = l_next ^ ((op_q == bf_pkg::OP_DEC) ? p_q[bf_pkg::KEY_SECOND]
                                                         : p_q[bf_pkg::KEY_PRE]);

  // table write source
  always_comb begin
    wr_go  = 1'b0;
    wr_idx = idx_q;
    wr_val = word_q;
    case (state_q)
      ST_LOAD: begin
        wr_go = (idx_q < bf_pkg::TABLE_WORDS);
      end
      ST_WR0: begin
        wr_go  = 1'b1;
        wr_idx = pair_q;
        wr_val = l_q;
      end
      ST_WR1: begin
        wr_go  = 1'b1;
        wr_idx = pair_q + 11'd1;
        wr_val = r_q;
      end
      default: begin
        wr_go = 1'b0;
      end
    endcase
  end

  assign box_ofs = wr_idx - bf_pkg::BOX_BASE;

  always_comb begin
    state_d     = state_q;
    round_d     = round_q;
    pair_d      = pair_q;
    op_d        = op_q;
    idx_d       = idx_q;
    word_d      = word_q;
    key_d       = key_q;
    l_d         = l_q;
    r_d         = r_q;
    t_d         = t_q;
    p_d         = p_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_data_d  = out_data_q;

    box_req         = '0;
    box_req.rd_word = p_q[key_idx] ^ l_q;

    if (wr_go) begin
      if (wr_idx < bf_pkg::BOX_BASE) begin
        p_d[wr_idx[4:0]] = wr_val;
      end else begin
        box_req.wr_en   = 1'b1;
        box_req.wr_box  = box_ofs[9:8];
        box_req.wr_addr = box_ofs[7:0];
        box_req.wr_data = wr_val;
      end
    end

    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          op_d    = in_data_i.operation;
          idx_d   = in_data_i.table_index;
          word_d  = in_data_i.table_word;
          key_d   = in_data_i.key_bytes;
          l_d     = in_data_i.block_first;
          r_d     = in_data_i.block_second;
          round_d = '0;
          case (in_data_i.operation)
            bf_pkg::OP_LOAD: state_d = ST_LOAD;
            bf_pkg::OP_MIX:  state_d = ST_KXOR;
            default:         state_d = ST_RD;
          endcase
        end
      end
      ST_LOAD: begin
        state_d = ST_DONE;
      end
      ST_KXOR: begin
        for (int j = 0; j < int'(bf_pkg::ROUND_KEYS); j++) begin
          p_d[j] = p_q[j] ^ (j[0] ? key_odd : key_even);
        end
        l_d     = '0;
        r_d     = '0;
        pair_d  = '0;
        round_d = '0;
        state_d = ST_RD;
      end
      ST_RD: begin
        t_d     = box_req.rd_word;
        state_d = ST_FN;
      end
      ST_FN: begin
        round_d = round_q + 4'd1;
        if (round_q == bf_pkg::LAST_ROUND) begin
          l_d     = fin_first;
          r_d     = fin_second;
          state_d = (op_q == bf_pkg::OP_MIX) ? ST_WR0 : ST_DONE;
        end else begin
          l_d     = l_next;
          r_d     = t_q;
          state_d = ST_RD;
        end
      end
      ST_WR0: begin
        state_d = ST_WR1;
      end
      ST_WR1: begin
        round_d = '0;
        pair_d  = pair_q + 11'd2;
        state_d = (pair_q == bf_pkg::LAST_PAIR) ? ST_DONE : ST_RD;
      end
      ST_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d = 1'b1;
          if ((op_q == bf_pkg::OP_ENC) || (op_q == bf_pkg::OP_DEC)) begin
            out_data_d.result_first  = l_q;
            out_data_d.result_second = r_q;
          end else begin
            out_data_d = '0;
          end
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    round_q    <= round_d;
    pair_q     <= pair_d;
    op_q       <= op_d;
    idx_q      <= idx_d;
    word_q     <= word_d;
    key_q      <= key_d;
    l_q        <= l_d;
    r_q        <= r_d;
    t_q        <= t_d;
    p_q        <= p_d;
    out_data_q <= out_data_d;
  end

  // a new result only appears after the publish step
  a_rise_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(state_q == ST_DONE))
    else $error("result raised outside the publish step");

  // every f evaluation follows its box lookup
  a_fn_after_rd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_FN) |-> $past(state_q == ST_RD))
    else $error("round function used without a lookup");

  // table rewrite only happens during key mix
  a_wr_mix: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == ST_WR0) || (state_q == ST_WR1)) |-> (op_q == bf_pkg::OP_MIX))
    else $error("pair write outside key mix");

  // pair writes always start on an even word
  a_pair_even: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_WR0) |-> !pair_q[0])
    else $error("odd pair index");

  // an accepted transaction leaves idle
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (state_q != ST_IDLE))
    else $error("sequencer stayed idle after acceptance");

endmodule
